@@ hdl/quaternion_to_rotation_matrix_macros.svh @@
// assertion macros for the quaternion to rotation matrix block
`ifndef QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define Q2R_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define Q2R_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

@@ hdl/q2r_pkg.sv @@
// shared types and constants for the quaternion to rotation matrix block
`default_nettype none
package q2r_pkg;
    localparam int FracBits = 14;
    localparam int CompW    = 16;
    localparam int SumW     = 33;
    localparam int MagW     = 17;
    localparam int SqrtSteps = 17;
    localparam int DivQW    = 16;
    localparam int DivSteps = 16;
    localparam int InW      = 64;
    localparam int OutW     = 145;

    typedef struct packed {
        logic signed [CompW-1:0] x;
        logic signed [CompW-1:0] y;
        logic signed [CompW-1:0] z;
        logic signed [CompW-1:0] w;
    } t_quat;

    typedef struct packed {
        logic [8:0][CompW-1:0] entry;
        logic                  too_small;
    } t_result;

    // round to component format, ties away from zero, saturate to +-1
    function automatic logic [CompW-1:0] narrow(input logic signed [35:0] v);
        logic [35:0] a;
        logic [35:0] r;
        logic [CompW-1:0] m;
        a = v[35] ? 36'(-v) : 36'(v);
        r = (a + 36'(1 << (FracBits - 1))) >> FracBits;
        if (r > 36'(1 << FracBits)) r = 36'(1 << FracBits);
        m = r[CompW-1:0];
        return v[35] ? CompW'(-m) : m;
    endfunction
endpackage
`default_nettype wire

@@ hdl/q2r_front.sv @@
// front end: sum of squares, pipelined square root and threshold test
`default_nettype none
module q2r_front import q2r_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire t_quat           i_quat,
    input  wire logic [14:0]     i_min_mag,
    output logic                 o_valid,
    output t_quat                o_quat,
    output logic [MagW-1:0]      o_mag,
    output logic                 o_small
);
    localparam int NS = SqrtSteps + 2;
    logic [NS-1:0]               r_v;
    t_quat                       r_q [NS];
    logic [SumW-1:0]             r_rem [NS];
    logic [MagW-1:0]             r_root [NS];
    logic [31:0]                 r_sq [4];
    logic [MagW-1:0]             r_mag;
    logic                        r_small;

    // stage 0: squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0]  <= i_quat;
            r_sq[0] <= 32'(i_quat.x * i_quat.x);
            r_sq[1] <= 32'(i_quat.y * i_quat.y);
            r_sq[2] <= 32'(i_quat.z * i_quat.z);
            r_sq[3] <= 32'(i_quat.w * i_quat.w);
            // stage 1: sum
            r_q[1]    <= r_q[0];
            r_rem[1]  <= SumW'(r_sq[0]) + SumW'(r_sq[1]) + SumW'(r_sq[2]) + SumW'(r_sq[3]);
            r_root[1] <= '0;
        end
    end

    // one result bit per stage, restoring square root
    for (genvar s = 0; s < SqrtSteps; s++) begin : g_sq
        localparam int B = SqrtSteps - 1 - s;
        logic [MagW-1:0] trial;
        logic [SumW+1:0] tsq;
        assign trial = r_root[s+1] | (MagW'(1) << B);
        assign tsq   = (SumW+2)'(trial) * (SumW+2)'(trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s+2]   <= r_q[s+1];
                r_rem[s+2] <= r_rem[s+1];
                r_root[s+2] <= (tsq <= (SumW+2)'(r_rem[s+1])) ? trial : r_root[s+1];
            end
        end
    end

    assign r_mag   = r_root[NS-1];
    assign r_small = (r_mag < MagW'(i_min_mag)) || (r_mag == '0);
    assign o_valid = r_v[NS-1];
    assign o_quat  = r_q[NS-1];
    assign o_mag   = r_mag;
    assign o_small = r_small;
endmodule
`default_nettype wire

@@ hdl/q2r_fifo.sv @@
// short queue between front and back
`default_nettype none
module q2r_fifo import q2r_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  wire logic [InW+MagW:0] i_data,
    input  wire logic            i_rd,
    output logic                 o_valid,
    output logic [InW+MagW:0]    o_data,
    output logic                 o_afull
);
    localparam int Depth = 32;
    logic [InW+MagW:0] r_mem [Depth];
    logic [5:0] r_wp, r_rp;
    logic [5:0] cnt;
    assign cnt = r_wp - r_rp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + 6'd1;
            if (i_rd && o_valid) r_rp <= r_rp + 6'd1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp[4:0]] <= i_data;
    end
    assign o_valid = cnt != '0;
    assign o_data  = r_mem[r_rp[4:0]];
    // leaves room for words still in the front pipeline
    assign o_afull = cnt >= 6'(Depth - SqrtSteps - 4);
endmodule
`default_nettype wire

@@ hdl/q2r_back.sv @@
// back end: pipelined normalization divide, products and output register
`default_nettype none
module q2r_back import q2r_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [InW+MagW:0] i_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output t_result              o_res
);
    localparam int NS = DivSteps + 4;
    logic en;
    logic [NS-1:0] r_v;
    // per component: sign, remainder numerator, quotient
    logic [3:0]            r_neg  [NS];
    logic [3:0][33:0]      r_num  [NS];
    logic [3:0][DivQW-1:0] r_quo  [NS];
    logic [MagW:0]         r_den  [NS];
    logic                  r_sm   [NS];
    t_quat                 r_raw  [NS];
    t_quat  n;
    logic signed [CompW-1:0] cx, cy, cz, cw;
    logic signed [31:0] r_p [9];
    logic r_sm2;
    logic r_ov;
    t_result r_out;

    assign en = !r_ov || i_ready;
    assign o_ready = en;

    // stage 0: set up the (2|q|*2^F + mag) over 2*mag divide
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_raw[0] <= t_quat'(i_data[InW+MagW:MagW+1]);
            r_sm[0]  <= i_data[0];
            r_den[0] <= {i_data[MagW:1], 1'b0};
            for (int k = 0; k < 4; k++) begin
                logic signed [CompW-1:0] c;
                logic [CompW-1:0] a;
                c = i_data[MagW+1+16*k +: 16];
                a = c[15] ? 16'(-c) : 16'(c);
                r_neg[0][k] <= c[15];
                r_num[0][k] <= 34'({a, 15'b0}) + 34'(i_data[MagW:1]);
                r_quo[0][k] <= '0;
            end
        end
    end

    // one quotient bit per stage
    for (genvar s = 0; s < DivSteps; s++) begin : g_dv
        localparam int B = DivSteps - 1 - s;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_raw[s+1] <= r_raw[s];
                r_sm[s+1]  <= r_sm[s];
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
                for (int k = 0; k < 4; k++) begin
                    if (!r_sm[s] && (r_num[s][k] >= (34'(r_den[s]) << B))) begin
                        r_num[s+1][k] <= r_num[s][k] - (34'(r_den[s]) << B);
                        r_quo[s+1][k] <= r_quo[s][k] | (DivQW'(1) << B);
                    end else begin
                        r_num[s+1][k] <= r_num[s][k];
                        r_quo[s+1][k] <= r_quo[s][k];
                    end
                end
            end
        end
    end

    // pick normalized or raw components
    always_comb begin
        n.x = r_neg[DivSteps][3] ? CompW'(-r_quo[DivSteps][3]) : r_quo[DivSteps][3];
        n.y = r_neg[DivSteps][2] ? CompW'(-r_quo[DivSteps][2]) : r_quo[DivSteps][2];
        n.z = r_neg[DivSteps][1] ? CompW'(-r_quo[DivSteps][1]) : r_quo[DivSteps][1];
        n.w = r_neg[DivSteps][0] ? CompW'(-r_quo[DivSteps][0]) : r_quo[DivSteps][0];
        cx = r_sm[DivSteps] ? r_raw[DivSteps].x : n.x;
        cy = r_sm[DivSteps] ? r_raw[DivSteps].y : n.y;
        cz = r_sm[DivSteps] ? r_raw[DivSteps].z : n.z;
        cw = r_sm[DivSteps] ? r_raw[DivSteps].w : n.w;
    end

    // products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0] <= cx * cx; r_p[1] <= cy * cy; r_p[2] <= cz * cz;
            r_p[3] <= cx * cy; r_p[4] <= cx * cz; r_p[5] <= cy * cz;
            r_p[6] <= cw * cx; r_p[7] <= cw * cy; r_p[8] <= cw * cz;
            r_sm2  <= r_sm[DivSteps];
        end
    end

    // sums, rounding and output register
    always_ff @(posedge i_clk) begin
        logic signed [35:0] one;
        one = 36'sd1 <<< (2 * FracBits);
        if (!i_rst_n) begin
            r_v <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v  <= {r_v[NS-2:0], i_valid};
            r_ov <= r_v[DivSteps+1];
        end
        if (en) begin
            r_out.entry[0] <= narrow(one - 36'(r_p[1] + 36'(r_p[2])) * 2);
            r_out.entry[1] <= narrow((36'(r_p[3]) + 36'(r_p[8])) * 2);
            r_out.entry[2] <= narrow((36'(r_p[4]) - 36'(r_p[7])) * 2);
            r_out.entry[3] <= narrow((36'(r_p[3]) - 36'(r_p[8])) * 2);
            r_out.entry[4] <= narrow(one - (36'(r_p[0]) + 36'(r_p[2])) * 2);
            r_out.entry[5] <= narrow((36'(r_p[5]) + 36'(r_p[6])) * 2);
            r_out.entry[6] <= narrow((36'(r_p[4]) + 36'(r_p[7])) * 2);
            r_out.entry[7] <= narrow((36'(r_p[5]) - 36'(r_p[6])) * 2);
            r_out.entry[8] <= narrow(one - (36'(r_p[0]) + 36'(r_p[1])) * 2);
            r_out.too_small <= r_sm2;
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_out;
endmodule
`default_nettype wire

@@ hdl/quaternion_to_rotation_matrix.sv @@
// top level of the quaternion to rotation matrix block
// Takes one quaternion word per cycle while s_axis_tready is high and returns one
// matrix word per word taken. The path runs through 19 front stages (squares, sum,
// 17 square-root steps), the queue write, then divide setup, 16 divide steps,
// products and the output register. Sustained rate is one word per cycle while
// m_axis_tready stays high; input stalls only when 11 or more words wait in the queue.
`default_nettype none
module quaternion_to_rotation_matrix import q2r_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [14:0]   i_cfg_wdata,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // quat_x[15:0], quat_y[31:16], quat_z[47:32], quat_w[63:48]
    input  wire logic [63:0]   s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // entry_0 to entry_8 at 16 bits each from bit 0, too_small[144], zero pad
    output logic [151:0]       m_axis_tdata
);
    logic [14:0] r_min;
    t_quat q;
    logic fv, fs, afull, qv, brd;
    t_quat fq;
    logic [MagW-1:0] fm;
    logic [InW+MagW:0] qd;
    t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_min <= 15'd1;
        else if (i_cfg_we) r_min <= i_cfg_wdata;
    end

    assign q.x = s_axis_tdata[15:0];
    assign q.y = s_axis_tdata[31:16];
    assign q.z = s_axis_tdata[47:32];
    assign q.w = s_axis_tdata[63:48];
    assign s_axis_tready = !afull;

    q2r_front u_front (.i_clk, .i_rst_n, .i_en(1'b1),
        .i_valid(s_axis_tvalid && !afull), .i_quat(q), .i_min_mag(r_min),
        .o_valid(fv), .o_quat(fq), .o_mag(fm), .o_small(fs));

    q2r_fifo u_fifo (.i_clk, .i_rst_n, .i_wr(fv), .i_data({fq, fm, fs}),
        .i_rd(brd), .o_valid(qv), .o_data(qd), .o_afull(afull));

    q2r_back u_back (.i_clk, .i_rst_n, .i_valid(qv), .o_ready(brd), .i_data(qd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res));

    always_comb begin
        m_axis_tdata = '0;
        for (int k = 0; k < 9; k++) m_axis_tdata[16*k +: 16] = res.entry[k];
        m_axis_tdata[144] = res.too_small;
    end
endmodule
`default_nettype wire

@@ hdl/q2r_checker.sv @@
// port checker for the quaternion to rotation matrix block
`default_nettype none
`include "quaternion_to_rotation_matrix_macros.svh"
module q2r_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [151:0] m_axis_tdata
);
    `Q2R_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed")
    `Q2R_ASSERT_IMP(a_pad, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[151:145] == 7'd0, "pad bits set")
    `Q2R_ASSERT_IMP(a_rng, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[0 +: 16] != 16'h8000, "entry range")
    `Q2R_ASSERT_IMP(a_rdy, i_clk, i_rst_n, s_axis_tvalid, !$isunknown(s_axis_tready), "tready unknown")
endmodule
bind quaternion_to_rotation_matrix q2r_checker u_chk (.*);
`default_nettype wire

@@ sim/quaternion_to_rotation_matrix_tb.sv @@
// self-checking testbench for the quaternion to rotation matrix block
`default_nettype none
module quaternion_to_rotation_matrix_tb;
    import q2r_pkg::*;

    localparam int FB = 14;
    localparam int MaxCycles = 400000;

    // expected matrix words, oldest first, with mismatch bookkeeping
    class matrix_scoreboard;
        logic [144:0] pending[$];
        logic [14:0]  threshold;
        int           mismatches;
        int           checked;
        int           small_seen;

        function new();
            threshold = 15'd1;
            mismatches = 0;
            checked = 0;
            small_seen = 0;
        endfunction

        static function longint unsigned isqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= root + bitv) begin
                    v -= root + bitv;
                    root = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            return root;
        endfunction

        static function longint unit_comp(longint q, longint unsigned mag);
            longint unsigned num;
            longint unsigned n;
            num = (q < 0 ? -q : q) << FB;
            n = (2 * num + mag) / (2 * mag);
            return q < 0 ? -longint'(n) : longint'(n);
        endfunction

        static function logic [15:0] round_sat(longint v);
            longint unsigned r;
            longint s;
            r = ((v < 0 ? -v : v) + (64'd1 << (FB - 1))) >> FB;
            if (r > (64'd1 << FB)) r = 64'd1 << FB;
            s = v < 0 ? -longint'(r) : longint'(r);
            return s[15:0];
        endfunction

        // compute the matrix for one accepted quaternion
        function void note_quat(logic [63:0] d);
            longint c[4];
            longint unsigned sq;
            longint unsigned mag;
            longint one;
            longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
            bit tiny;
            logic [144:0] e;
            sq = 0;
            one = 64'sd1 <<< (2 * FB);
            for (int i = 0; i < 4; i++) begin
                c[i] = longint'($signed(d[16*i +: 16]));
                sq += c[i] * c[i];
            end
            mag = isqrt(sq);
            tiny = (mag < threshold) || (mag == 0);
            if (!tiny) for (int i = 0; i < 4; i++) c[i] = unit_comp(c[i], mag);
            xx = c[0] * c[0]; yy = c[1] * c[1]; zz = c[2] * c[2];
            xy = 2 * c[0] * c[1]; xz = 2 * c[0] * c[2]; yz = 2 * c[1] * c[2];
            wx = 2 * c[3] * c[0]; wy = 2 * c[3] * c[1]; wz = 2 * c[3] * c[2];
            e[15:0]    = round_sat(one - 2 * (yy + zz));
            e[31:16]   = round_sat(xy + wz);
            e[47:32]   = round_sat(xz - wy);
            e[63:48]   = round_sat(xy - wz);
            e[79:64]   = round_sat(one - 2 * (xx + zz));
            e[95:80]   = round_sat(yz + wx);
            e[111:96]  = round_sat(xz + wy);
            e[127:112] = round_sat(yz - wx);
            e[143:128] = round_sat(one - 2 * (xx + yy));
            e[144]     = tiny;
            pending.push_back(e);
        endfunction

        // compare one result word field by field
        function void check_matrix(logic [151:0] d);
            logic [144:0] e;
            bit bad;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", d);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e[144]) small_seen++;
            bad = 0;
            for (int i = 0; i < 9; i++) begin
                if (d[16*i +: 16] !== e[16*i +: 16]) begin
                    bad = 1;
                    if (mismatches < 10)
                        $display("entry slot %0d: expected %h got %h", i,
                                 e[16*i +: 16], d[16*i +: 16]);
                end
            end
            if (d[144] !== e[144]) begin
                bad = 1;
                if (mismatches < 10)
                    $display("too_small: expected %b got %b", e[144], d[144]);
            end
            if (bad) mismatches++;
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_we = 0;
    logic [14:0]  i_cfg_wdata = '0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [151:0] m_axis_tdata;

    matrix_scoreboard sb = new();
    int cycles = 0;
    int sent = 0;

    quaternion_to_rotation_matrix u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // timeout watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MaxCycles) begin
            $display("quaternion_to_rotation_matrix_tb: FAIL");
            $finish;
        end
    end

    // result side: random back-pressure (ready held high when calm_sink is set), check at the accepting edge
    bit calm_sink = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_matrix(m_axis_tdata);
            if (calm_sink) m_axis_tready <= 1'b1;
            else m_axis_tready <= (gap_len() == 0) || ($urandom_range(0, 3) != 0
                                   && gap_len() < 4);
        end
    end

    task automatic send_word(logic [63:0] d);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_quat(d);
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [14:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.threshold = v;
    endtask

    function automatic logic [63:0] pack_q(int x, int y, int z, int w);
        return {w[15:0], z[15:0], y[15:0], x[15:0]};
    endfunction

    // mostly random components shifted right by 3, some shifted further or left at full random magnitude
    function automatic logic [63:0] rand_quat();
        int r;
        int sh;
        logic [63:0] d;
        r = $urandom_range(0, 9);
        d = {$urandom, $urandom};
        if (r < 2) return d;
        sh = (r < 7) ? 3 : $urandom_range(4, 14);
        for (int i = 0; i < 4; i++)
            d[16*i +: 16] = 16'($signed(d[16*i +: 16]) >>> sh);
        return d;
    endfunction

    logic [14:0] settings[5] = '{15'd0, 15'd16384, 15'd8000, 15'd200, 15'd1};

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, zero, identity, raw path saturation
        send_word(pack_q(0, 0, 0, 16384));
        send_word(pack_q(16384, 0, 0, 0));
        send_word(pack_q(0, 16384, 0, 0));
        send_word(pack_q(0, 0, 16384, 0));
        send_word(pack_q(0, 0, 0, 0));
        send_word(pack_q(32767, 32767, 32767, 32767));
        send_word(pack_q(-32768, -32768, -32768, -32768));
        send_word(pack_q(-32768, 32767, -32768, 32767));
        send_word(pack_q(8192, 8192, 8192, 8192));
        send_word(pack_q(1, 0, 0, 0));
        send_word(pack_q(-1, -1, 1, 1));
        send_word(pack_q(11585, 0, 0, -11585));
        drain();
        // zero threshold with the all-zero quaternion and a tiny one
        write_threshold(15'd0);
        send_word(pack_q(0, 0, 0, 0));
        send_word(pack_q(0, 0, 1, 0));
        // maximum threshold sends words with magnitude below 32767 down the raw path
        drain();
        write_threshold(15'h7fff);
        send_word(pack_q(20000, -20000, 3000, 100));
        send_word(pack_q(-32768, 32767, 0, 0));
        send_word(pack_q(5000, 5000, 5000, 5000));
        drain();

        // random phases over several thresholds
        foreach (settings[k]) begin
            write_threshold(settings[k]);
            calm_sink = (k == 2);
            repeat (300) send_word(rand_quat());
            drain();
        end
        calm_sink = 0;

        $display("covered %0d quaternions, %0d results checked, %0d unnormalized",
                 sent, sb.checked, sb.small_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("quaternion_to_rotation_matrix_tb: PASS");
        else
            $display("quaternion_to_rotation_matrix_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+hdl
hdl/q2r_pkg.sv
hdl/q2r_front.sv
hdl/q2r_fifo.sv
hdl/q2r_back.sv
hdl/quaternion_to_rotation_matrix.sv
hdl/q2r_checker.sv
sim/quaternion_to_rotation_matrix_tb.sv
